### rtl/core/mrr_pkg.sv
// Shared types, sizes and codes for the Modbus RTU request receiver.
package mrr_pkg;

  // Frame store sizing
  localparam int BUFFER_BYTES = 64;
  localparam int STORE_DEPTH  = BUFFER_BYTES - 1;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W        = $clog2(BUFFER_BYTES);
  localparam int LEN_W        = ((CNT_W > 8) ? CNT_W : 8) + 1;

  // Frame layout
  localparam int HDR_BYTES      = 7;
  localparam int CHECK_FROM     = 5;
  localparam int SINGLE_LEN     = 8;
  localparam int MULTI_OVERHEAD = 9;
  localparam int EXC_CRC_BYTES  = 3;
  localparam int EXC_BYTES      = 5;

  // Input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_PAY = 2'd1;
  localparam logic [1:0] KIND_EXC = 2'd2;

  // Function codes and exception codes
  localparam logic [7:0] FC_SINGLE_MIN        = 8'h01;
  localparam logic [7:0] FC_SINGLE_MAX        = 8'h06;
  localparam logic [7:0] FC_WRITE_COILS       = 8'h0F;
  localparam logic [7:0] FC_WRITE_REGS        = 8'h10;
  localparam logic [7:0] FC_EXC_FLAG          = 8'h80;
  localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'h01;

  // CRC-16 (reflected)
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration registers
  localparam int         CFG_INDEX_W       = 1;
  localparam logic       CFG_OWN_ADDR      = 1'b0;
  localparam logic       CFG_IDLE_TIMEOUT  = 1'b1;
  localparam logic [7:0]  SLAVE_RESET      = 8'h00;
  localparam logic [15:0] TIMEOUT_RESET    = 16'd100;
  localparam logic [15:0] TICKS_MAX        = 16'hFFFF;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [7:0]  data_byte;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic init;
    logic feed;
  } crc_ctl_t;

endpackage

### rtl/core/mrr_crc16.sv
// Shared CRC-16 unit: one byte folded into the running CRC per cycle.
module mrr_crc16 (
  input  logic             clk,
  input  mrr_pkg::crc_ctl_t ctl,
  input  logic [7:0]       data,
  output logic [15:0]      crc
);
  import mrr_pkg::*;

  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  // Load the seed or fold in one byte
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      crc <= CRC_INIT;
    end else if (ctl.feed) begin
      crc <= crc_byte(crc, data);
    end
  end

endmodule

### rtl/core/mrr_frame_store.sv
// Frame byte memory: one write port, one registered read port.
module mrr_frame_store (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [mrr_pkg::ADDR_W-1:0] wr_addr,
  input  logic [7:0]                wr_data,
  input  logic                      rd_en,
  input  logic [mrr_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                rd_data
);
  import mrr_pkg::*;

  logic [7:0] mem [STORE_DEPTH];

  // Write received bytes, register read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/modbus_rtu_request_receiver.sv
// Modbus RTU request receiver: frame collection, checks, CRC walk and result output.
//
// Channels: the item channel carries either a received byte (opcode 0) or a
// one-millisecond tick (opcode 1); the result channel carries request
// headers, payload bytes and exception-frame bytes, with last set on the
// final word caused by one item; the cfg channel writes the slave address
// (index 0) and the idle timeout in ticks (index 1) and is always ready.
// A tick is handled in idle. A byte that completes nothing passes through
// the check state and back to idle. A complete frame of N bytes is walked
// once through the frame store and the shared CRC unit (one store read per
// cycle); the header follows, then each payload byte passes through a store
// read state, then an output state. An illegal function code feeds 3 bytes
// into the CRC unit, then gives 5 output words; item_ready stays low throughout.
// A result waits in an output register; item_ready is high again as soon
// as the last result is loaded, even if it has not been taken. When the
// result receiver stalls, the sequencer holds until the register frees.
// Reset clears the byte count and idle counter, sets slave address 0 and
// timeout 100; the frame store itself is not cleared.
module modbus_rtu_request_receiver (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  mrr_pkg::in_item_t              item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output mrr_pkg::out_item_t             result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mrr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import mrr_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_EXC_CRC = 3'd2;
  localparam logic [2:0] S_EXC_OUT = 3'd3;
  localparam logic [2:0] S_WALK    = 3'd4;
  localparam logic [2:0] S_HDR     = 3'd5;
  localparam logic [2:0] S_PAY_RD  = 3'd6;
  localparam logic [2:0] S_PAY_OUT = 3'd7;

  logic [2:0]       state;
  logic [7:0]       own_addr;
  logic [15:0]      idle_timeout;
  logic [15:0]      idle_ticks;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       hdr [HDR_BYTES];
  logic [CNT_W-1:0] step;
  logic             rd_pend;
  logic [CNT_W-1:0] rd_idx;
  logic             crc_lo_ok;

  logic             accept;
  logic             accept_byte;
  logic [CNT_W-1:0] fill;
  logic             store_ok;
  logic             wr_en;
  logic             rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  crc_ctl_t         crc_ctl;
  logic [7:0]       crc_data;
  logic [15:0]      crc;
  logic [7:0]       fc;
  logic             is_single;
  logic             is_multi;
  logic [LEN_W-1:0] frame_len;
  logic [CNT_W-1:0] body;
  logic [7:0]       cnt;
  logic [7:0]       exc_byte;
  logic             slot_free;
  logic             load;
  out_item_t        result_next;

  assign item_ready  = (state == S_IDLE);
  assign cfg_ready   = 1'b1;
  assign accept      = item_valid && item_ready;
  assign accept_byte = accept && (item.opcode == OP_BYTE);

  // Drop the held bytes on an idle gap, then place the new byte
  assign fill     = (idle_ticks > idle_timeout) ? '0 : byte_count;
  assign store_ok = (fill < CNT_W'(STORE_DEPTH));
  assign wr_en    = accept_byte && store_ok;

  // Decode the held header
  assign fc        = hdr[1];
  assign is_single = (fc >= FC_SINGLE_MIN) && (fc <= FC_SINGLE_MAX);
  assign is_multi  = (fc == FC_WRITE_COILS) || (fc == FC_WRITE_REGS);
  assign frame_len = LEN_W'(hdr[6]) + LEN_W'(MULTI_OVERHEAD);
  assign body      = byte_count - CNT_W'(2);
  assign cnt       = is_multi ? hdr[6] : 8'h00;
  assign slot_free = !result_valid || result_ready;

  // Exception frame bytes by step
  always_comb begin
    case (step[2:0])
      3'd0:    exc_byte = own_addr;
      3'd1:    exc_byte = fc | FC_EXC_FLAG;
      3'd2:    exc_byte = EXC_ILLEGAL_FUNCTION;
      3'd3:    exc_byte = crc[7:0];
      default: exc_byte = crc[15:8];
    endcase
  end

  // Steer the store read port, the CRC unit and the output register
  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = step[ADDR_W-1:0];
    crc_ctl      = '0;
    crc_data     = rd_data;
    load         = 1'b0;
    result_next  = '0;
    result_next.function_code = fc;
    unique case (state)
      S_CHECK: begin
        crc_ctl.init = 1'b1;
      end
      S_EXC_CRC: begin
        crc_ctl.feed = 1'b1;
        crc_data     = exc_byte;
      end
      S_EXC_OUT: begin
        load                  = slot_free;
        result_next.kind      = KIND_EXC;
        result_next.data_byte = exc_byte;
        result_next.last      = (step == CNT_W'(EXC_BYTES - 1));
      end
      S_WALK: begin
        rd_en        = (step < byte_count);
        crc_ctl.feed = rd_pend && (rd_idx < body);
      end
      S_HDR: begin
        load                      = slot_free;
        result_next.kind          = KIND_HDR;
        result_next.start_address = {hdr[2], hdr[3]};
        result_next.quantity      = {hdr[4], hdr[5]};
        result_next.data_byte     = cnt;
        result_next.last          = (cnt == 8'h00);
      end
      S_PAY_RD: begin
        rd_en = 1'b1;
      end
      S_PAY_OUT: begin
        load                      = slot_free;
        result_next.kind          = KIND_PAY;
        result_next.start_address = {hdr[2], hdr[3]};
        result_next.quantity      = {hdr[4], hdr[5]};
        result_next.data_byte     = rd_data;
        result_next.last          = (step == body - CNT_W'(1));
      end
      default: begin
      end
    endcase
  end

  mrr_frame_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill[ADDR_W-1:0]),
    .wr_data (item.rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mrr_crc16 u_crc (
    .clk  (clk),
    .ctl  (crc_ctl),
    .data (crc_data),
    .crc  (crc)
  );

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      own_addr     <= SLAVE_RESET;
      idle_timeout <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OWN_ADDR:     own_addr     <= cfg_data[7:0];
        CFG_IDLE_TIMEOUT: idle_timeout <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Capture the fixed header bytes as they arrive
  always_ff @(posedge clk) begin
    if (wr_en && (fill < CNT_W'(HDR_BYTES))) begin
      hdr[fill[2:0]] <= item.rx_byte;
    end
  end

  // Hold a result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idle_ticks <= '0;
      byte_count <= '0;
      step       <= '0;
      rd_pend    <= 1'b0;
      rd_idx     <= '0;
      crc_lo_ok  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.opcode == OP_TICK) begin
              if (idle_ticks != TICKS_MAX) begin
                idle_ticks <= idle_ticks + 16'd1;
              end
            end else begin
              idle_ticks <= '0;
              byte_count <= store_ok ? fill + CNT_W'(1) : fill;
              state      <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          step    <= '0;
          rd_pend <= 1'b0;
          if (byte_count < CNT_W'(CHECK_FROM)) begin
            state <= S_IDLE;
          end else if (hdr[0] != own_addr || own_addr == 8'h00) begin
            byte_count <= '0;
            state      <= S_IDLE;
          end else if (is_single) begin
            state <= (byte_count == CNT_W'(SINGLE_LEN)) ? S_WALK : S_IDLE;
          end else if (is_multi) begin
            if (byte_count >= CNT_W'(HDR_BYTES) && LEN_W'(byte_count) == frame_len) begin
              state <= S_WALK;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_EXC_CRC;
          end
        end
        S_EXC_CRC: begin
          if (step == CNT_W'(EXC_CRC_BYTES - 1)) begin
            step  <= '0;
            state <= S_EXC_OUT;
          end else begin
            step <= step + CNT_W'(1);
          end
        end
        S_EXC_OUT: begin
          if (slot_free) begin
            step <= step + CNT_W'(1);
            if (step == CNT_W'(EXC_BYTES - 1)) begin
              byte_count <= '0;
              state      <= S_IDLE;
            end
          end
        end
        S_WALK: begin
          // Issue one read per cycle, consume the previous one
          if (rd_en) begin
            step <= step + CNT_W'(1);
          end
          rd_pend <= rd_en;
          rd_idx  <= step;
          if (rd_pend) begin
            if (rd_idx == body) begin
              crc_lo_ok <= (rd_data == crc[7:0]);
            end else if (rd_idx > body) begin
              if (crc_lo_ok && rd_data == crc[15:8]) begin
                state <= S_HDR;
              end else begin
                byte_count <= '0;
                state      <= S_IDLE;
              end
            end
          end
        end
        S_HDR: begin
          if (slot_free) begin
            step <= CNT_W'(HDR_BYTES);
            if (cnt == 8'h00) begin
              byte_count <= '0;
              state      <= S_IDLE;
            end else begin
              state <= S_PAY_RD;
            end
          end
        end
        S_PAY_RD: begin
          state <= S_PAY_OUT;
        end
        S_PAY_OUT: begin
          if (slot_free) begin
            if (step == body - CNT_W'(1)) begin
              byte_count <= '0;
              state      <= S_IDLE;
            end else begin
              step  <= step + CNT_W'(1);
              state <= S_PAY_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The held byte count never exceeds the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(STORE_DEPTH))
    else $error("byte count beyond frame store depth");

  // A tick leaves the sequencer idle and produces nothing
  a_tick_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && item.opcode == OP_TICK) |=> (state == S_IDLE))
    else $error("tick started a frame sequence");

  // An accepted byte restarts the idle counter
  a_byte_clears_idle: assert property (@(posedge clk) disable iff (rst)
    accept_byte |=> (idle_ticks == 16'd0))
    else $error("idle counter not cleared by a byte");

  // Payload words only follow multi-write requests
  a_payload_fc: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_PAY) |->
      (result.function_code == FC_WRITE_COILS || result.function_code == FC_WRITE_REGS))
    else $error("payload word for a single-item function");

  // A header with no byte count ends the item
  a_hdr_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_HDR && result.data_byte == 8'h00) |-> result.last)
    else $error("header without payload not marked last");

endmodule
